// File: rtl/spm_pkg.sv
// Shared types, codes and helpers for the sprite pixel priority mixer.
// No dependencies; every other file imports this package.
package spm_pkg;

    localparam int SLOT_COUNT_DEFAULT = 8;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] SRC_SPRITE     = 2'd0;
    localparam logic [1:0] SRC_BACKGROUND = 2'd1;
    localparam logic [1:0] SRC_BACKDROP   = 2'd2;

    localparam logic [1:0] CFG_SHOW_BG      = 2'd0;
    localparam logic [1:0] CFG_SHOW_SPR     = 2'd1;
    localparam logic [1:0] CFG_SHOW_LEFT_SPR = 2'd2;
    localparam logic [1:0] CFG_SHOW_LEFT_BG  = 2'd3;

    localparam logic [4:0] SPRITE_PALETTE_BASE = 5'd16;
    localparam logic [7:0] LEFT_COLUMN_END     = 8'd8;
    localparam logic [7:0] LAST_PIXEL_X        = 8'd255;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] slot;
        logic [7:0] x_start;
        logic [7:0] pattern_low;
        logic [7:0] pattern_high;
        logic [1:0] palette_select;
        logic       behind_background;
        logic       flip_horizontal;
        logic       sprite_zero_on_line;
        logic [3:0] bg_pixel;
        logic [7:0] pixel_x;
    } spm_item_t;

    typedef struct packed {
        logic [1:0] pixel_source;
        logic [4:0] palette_index;
        logic [1:0] sprite_color;
        logic [3:0] sprite_slot_won;
        logic       sprite_zero_hit;
    } spm_result_t;

    typedef struct packed {
        logic show_background;
        logic show_sprites;
        logic show_left_sprites;
        logic show_left_background;
    } spm_cfg_t;

    // per-slot strobes from the top level
    typedef struct packed {
        logic load;
        logic tick;
    } spm_slot_ctrl_t;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

endpackage

// File: rtl/spm_channels.sv
// Valid/ready channel interfaces for input requests and pixel results.
// Depends on spm_pkg for the payload structs.
interface spm_item_if
    import spm_pkg::*;
();
    logic      valid;
    logic      ready;
    spm_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spm_result_if
    import spm_pkg::*;
();
    logic        valid;
    logic        ready;
    spm_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/spm_slot.sv
// One sprite output slot: x down-counter, two pattern shift registers,
// palette and priority bit. Depends on spm_pkg.
module spm_slot
    import spm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  spm_slot_ctrl_t ctrl,
    input  spm_item_t      item,
    output logic [1:0]     color,
    output logic [1:0]     palette,
    output logic           behind
);

    logic [7:0] counter_reg;
    logic [7:0] plane_low_reg;
    logic [7:0] plane_high_reg;
    logic [1:0] palette_reg;
    logic       behind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg    <= '0;
            plane_low_reg  <= '0;
            plane_high_reg <= '0;
            palette_reg    <= '0;
            behind_reg     <= 1'b0;
        end
        else if (ctrl.load)
        begin
            counter_reg    <= item.x_start;
            plane_low_reg  <= item.flip_horizontal ? reverse8(item.pattern_low)
                                                   : item.pattern_low;
            plane_high_reg <= item.flip_horizontal ? reverse8(item.pattern_high)
                                                   : item.pattern_high;
            palette_reg    <= item.palette_select;
            behind_reg     <= item.behind_background;
        end
        else if (ctrl.tick)
        begin
            if (counter_reg != 8'd0)
            begin
                counter_reg <= counter_reg - 8'd1;
            end
            else
            begin
                plane_low_reg  <= {plane_low_reg[6:0], 1'b0};
                plane_high_reg <= {plane_high_reg[6:0], 1'b0};
            end
        end
    end

    // only a slot whose counter has run out shows a pixel
    assign color   = (counter_reg == 8'd0) ? {plane_high_reg[7], plane_low_reg[7]} : 2'd0;
    assign palette = palette_reg;
    assign behind  = behind_reg;

endmodule

// File: rtl/spm_mixer.sv
// Priority pick over the slots and sprite/background mix for one pixel.
// Depends on spm_pkg.
module spm_mixer
    import spm_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
)
(
    input  logic [1:0]  slot_color   [SLOT_COUNT],
    input  logic [1:0]  slot_palette [SLOT_COUNT],
    input  logic        slot_behind  [SLOT_COUNT],
    input  spm_cfg_t    cfg,
    input  logic [3:0]  bg_pixel,
    input  logic [7:0]  pixel_x,
    input  logic        zero_on_line,
    input  logic        hit_in,
    output spm_result_t result,
    output logic        hit_out
);

    localparam int WON_W = $clog2(SLOT_COUNT + 1);

    logic [SLOT_COUNT-1:0] win;
    logic [WON_W-1:0]      won;
    logic [31:0]           won_wide;
    logic [1:0]            color;
    logic [1:0]            pal;
    logic                  beh;
    logic [3:0]            bg;
    logic                  bg_opaque;
    logic                  hit_cond;
    logic                  sprite_front;

    always_comb
    begin
        logic taken;
        taken = 1'b0;
        win   = '0;
        won   = WON_W'(SLOT_COUNT);
        color = 2'd0;
        pal   = 2'd0;
        beh   = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (cfg.show_sprites && !taken && slot_color[i] != 2'd0)
            begin
                taken  = 1'b1;
                win[i] = 1'b1;
            end
        end
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (win[i])
            begin
                won   = WON_W'(i);
                color = slot_color[i];
                pal   = slot_palette[i];
                beh   = slot_behind[i];
            end
        end
    end

    assign bg        = cfg.show_background ? bg_pixel : 4'd0;
    assign bg_opaque = bg[1:0] != 2'd0;

    assign hit_cond = win[0] && zero_on_line && bg_opaque
                      && cfg.show_background && cfg.show_sprites
                      && ((pixel_x < LEFT_COLUMN_END)
                          ? (cfg.show_left_sprites && cfg.show_left_background)
                          : (pixel_x != LAST_PIXEL_X));
    assign hit_out  = hit_in | hit_cond;

    assign sprite_front = (color != 2'd0) && (!beh || !bg_opaque);
    assign won_wide     = 32'(won);

    always_comb
    begin
        result.sprite_color    = color;
        result.sprite_slot_won = won_wide[3:0];
        result.sprite_zero_hit = hit_out;
        if (sprite_front)
        begin
            result.pixel_source  = SRC_SPRITE;
            result.palette_index = SPRITE_PALETTE_BASE + {1'b0, pal, 2'b00} + {3'b000, color};
        end
        else if (bg_opaque)
        begin
            result.pixel_source  = SRC_BACKGROUND;
            result.palette_index = {1'b0, bg};
        end
        else
        begin
            result.pixel_source  = SRC_BACKDROP;
            result.palette_index = 5'd0;
        end
    end

endmodule

// File: rtl/sprite_pixel_priority_mixer.sv
// Top level of the sprite pixel priority mixer: request register, slot array,
// mixer and result register. Depends on spm_pkg, spm_channels, spm_slot, spm_mixer.
//
// Usage:
//   items   - request channel (valid/ready). opcode selects load slot, pixel
//             tick or clear of the sprite zero hit flag; opcode 3 is dropped.
//   results - one result per pixel tick: source, palette index, winning color
//             and slot, sticky sprite zero hit. Loads and clears give none.
//   cfg_we/cfg_index/cfg_data - write-only register port for the four enables;
//             write only while no request is in flight.
// Timing: a request is registered on acceptance and processed from the request
// register; a tick loads its result into the result register when it retires.
// One request per cycle is sustained while the receiver takes results; a tick
// waits otherwise. The slot update and mix lie between the request register and
// the result register.
// Reset clears all slots (transparent, counter zero), both flags, the enables
// and both valid bits. When the receiver stalls, a pending tick waits in the
// request register while the result is held; loads and clears still retire.
module sprite_pixel_priority_mixer
    import spm_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    spm_item_if.sink      items,
    spm_result_if.source  results,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic          cfg_data
);

    spm_cfg_t    cfg_reg;
    logic        in_valid_reg;
    spm_item_t   in_reg;
    logic        out_valid_reg;
    spm_result_t out_reg;
    logic        zero_on_line_reg;
    logic        hit_reg;

    logic        is_tick;
    logic        is_load;
    logic        is_clear;
    logic        advance;
    logic        hit_next;
    spm_result_t result;

    logic [1:0]  slot_color   [SLOT_COUNT];
    logic [1:0]  slot_palette [SLOT_COUNT];
    logic        slot_behind  [SLOT_COUNT];

    assign is_tick  = in_reg.opcode == OP_TICK;
    assign is_load  = in_reg.opcode == OP_LOAD;
    assign is_clear = in_reg.opcode == OP_CLEAR;

    // a tick retires only if the result register is free or being drained
    assign advance     = in_valid_reg && !(is_tick && out_valid_reg && !results.ready);
    assign items.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SHOW_BG:       cfg_reg.show_background      <= cfg_data;
                CFG_SHOW_SPR:      cfg_reg.show_sprites         <= cfg_data;
                CFG_SHOW_LEFT_SPR: cfg_reg.show_left_sprites    <= cfg_data;
                CFG_SHOW_LEFT_BG:  cfg_reg.show_left_background <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            zero_on_line_reg <= 1'b0;
            hit_reg          <= 1'b0;
        end
        else
        begin
            if (items.ready)
            begin
                in_valid_reg <= items.valid;
            end
            if (advance && is_tick)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && is_load && 32'(in_reg.slot) < SLOT_COUNT)
            begin
                zero_on_line_reg <= in_reg.sprite_zero_on_line;
            end
            if (advance && is_clear)
            begin
                hit_reg <= 1'b0;
            end
            else if (advance && is_tick)
            begin
                hit_reg <= hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            in_reg <= items.data;
        end
        if (advance && is_tick)
        begin
            out_reg <= result;
        end
    end

    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++)
        begin : g_slot
            spm_slot_ctrl_t ctrl;
            assign ctrl.load = advance && is_load && (32'(in_reg.slot) == g);
            assign ctrl.tick = advance && is_tick && cfg_reg.show_sprites;

            spm_slot u_slot (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .item    (in_reg),
                .color   (slot_color[g]),
                .palette (slot_palette[g]),
                .behind  (slot_behind[g])
            );
        end
    endgenerate

    spm_mixer #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_mixer (
        .slot_color   (slot_color),
        .slot_palette (slot_palette),
        .slot_behind  (slot_behind),
        .cfg          (cfg_reg),
        .bg_pixel     (in_reg.bg_pixel),
        .pixel_x      (in_reg.pixel_x),
        .zero_on_line (zero_on_line_reg),
        .hit_in       (hit_reg),
        .result       (result),
        .hit_out      (hit_next)
    );

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

endmodule
